FILE: rtl/dual_path_rtp_merge_controller_assert.svh
// Assertion macros used by the checker file of the merge controller.
`ifndef DUAL_PATH_RTP_MERGE_CONTROLLER_ASSERT_SVH
`define DUAL_PATH_RTP_MERGE_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPRMC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DPRMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/dprmc_pkg.sv
package dprmc_pkg;

    localparam int AGE_W  = 24;
    localparam int SEQ_W  = 16;
    localparam int LOST_W = 17;

    localparam logic [AGE_W-1:0] AGE_MAX       = '1;
    localparam logic [AGE_W-1:0] THRESH_RESET  = 24'd20000;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic REG_THRESHOLD = 1'b0;

    typedef enum logic [2:0] {
        ST_TICK          = 3'd0,
        ST_DELIVERED     = 3'd1,
        ST_RECOVERED     = 3'd2,
        ST_RECOVERY_FAIL = 3'd3,
        ST_NOT_PRIMARY   = 3'd4,
        ST_LOSS          = 3'd5,
        ST_SWITCHED      = 3'd6,
        ST_READ_FAIL     = 3'd7
    } t_status;

    typedef struct packed {
        logic [1:0] online;
        logic [1:0] offline_now;
    } t_path_info;

    typedef struct packed {
        t_status           status;
        logic [SEQ_W-1:0]  deliver_seq;
        logic              event_taken;
        logic              master_path;
        logic [LOST_W-1:0] pending_lost;
    } t_result;

endpackage

FILE: rtl/dprmc_paths.sv
module dprmc_paths (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_cmd,
    input  logic                      i_src_index,
    input  logic                      i_recovering,
    input  logic [dprmc_pkg::AGE_W-1:0] i_threshold,
    output dprmc_pkg::t_path_info     o_info
);
    import dprmc_pkg::*;

    logic [AGE_W-1:0] r_age [2];
    logic [AGE_W-1:0] n_age [2];
    logic [1:0]       r_online;
    logic [1:0]       n_online;
    logic [1:0]       online_eff;
    logic [1:0]       offline;
    logic [AGE_W-1:0] age_eff [2];

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            age_eff[p]    = (i_src_index == 1'(p)) ? '0 : r_age[p];
            online_eff[p] = r_online[p] | (i_src_index == 1'(p));
            offline[p]    = online_eff[p] && (age_eff[p] > i_threshold);
        end
    end

    always_comb begin
        n_age    = r_age;
        n_online = r_online;
        if (i_accept) begin
            if (i_cmd == CMD_TICK) begin
                for (int p = 0; p < 2; p++) begin
                    if (r_age[p] != AGE_MAX) begin
                        n_age[p] = AGE_W'(r_age[p] + 1'b1);
                    end
                end
            end else if (!i_recovering) begin
                n_age    = age_eff;
                n_online = online_eff & ~offline;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age[0] <= '0;
            r_age[1] <= '0;
            r_online <= 2'b11;
        end else begin
            r_age    <= n_age;
            r_online <= n_online;
        end
    end

    assign o_info.online      = r_online;
    assign o_info.offline_now = offline;

endmodule

FILE: rtl/dprmc_seq.sv
module dprmc_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_cmd,
    input  logic                        i_src_index,
    input  logic [dprmc_pkg::SEQ_W-1:0] i_pkt_seq,
    input  logic                        i_secondary_has,
    input  logic                        i_master_read_ok,
    input  dprmc_pkg::t_path_info       i_info,
    output logic                        o_recovering,
    output dprmc_pkg::t_result          o_result
);
    import dprmc_pkg::*;

    logic              r_master;
    logic              n_master;
    logic              r_expect_valid;
    logic              n_expect_valid;
    logic [SEQ_W-1:0]  r_expect_seq;
    logic [SEQ_W-1:0]  n_expect_seq;
    logic [SEQ_W-1:0]  r_gap_end;
    logic [SEQ_W-1:0]  n_gap_end;
    logic [LOST_W-1:0] r_lost;
    logic [LOST_W-1:0] n_lost;
    logic              secondary;
    logic              sw0;
    logic              sw1;
    logic              m1;
    logic [SEQ_W-1:0]  exp_seq;
    t_status           status;
    logic [SEQ_W-1:0]  deliver_seq;
    logic              taken;

    assign o_recovering = (r_lost != '0);
    assign secondary    = ~r_master;
    assign sw0          = i_info.offline_now[0] && !r_master;
    assign m1           = sw0 ? 1'b1 : r_master;
    assign sw1          = i_info.offline_now[1] && m1;
    assign exp_seq      = r_expect_valid ? r_expect_seq : i_pkt_seq;

    always_comb begin
        n_master       = r_master;
        n_expect_valid = r_expect_valid;
        n_expect_seq   = r_expect_seq;
        n_gap_end      = r_gap_end;
        n_lost         = r_lost;
        status         = ST_TICK;
        deliver_seq    = r_expect_seq;
        taken          = 1'b0;
        priority if (i_cmd == CMD_TICK) begin
            status = ST_TICK;
        end else if (o_recovering) begin
            if (i_info.online[secondary] && i_secondary_has) begin
                n_lost       = (r_expect_seq == r_gap_end) ? '0 : LOST_W'(r_lost - 1'b1);
                n_expect_seq = SEQ_W'(r_expect_seq + 1'b1);
                status       = ST_RECOVERED;
            end else begin
                n_lost         = '0;
                n_expect_valid = 1'b0;
                status         = ST_RECOVERY_FAIL;
            end
        end else begin
            taken    = 1'b1;
            n_master = sw1 ? ~m1 : m1;
            priority if (sw0 || sw1) begin
                n_expect_valid = 1'b0;
                status         = ST_SWITCHED;
            end else if (i_src_index != r_master) begin
                status = ST_NOT_PRIMARY;
            end else begin
                n_expect_valid = 1'b1;
                n_gap_end      = i_pkt_seq;
                n_expect_seq   = exp_seq;
                deliver_seq    = exp_seq;
                priority if (exp_seq != i_pkt_seq) begin
                    n_lost = LOST_W'({1'b0, SEQ_W'(i_pkt_seq - exp_seq)}) + LOST_W'(1);
                    status = ST_LOSS;
                end else if (!i_master_read_ok) begin
                    status = ST_READ_FAIL;
                end else begin
                    n_expect_seq = SEQ_W'(exp_seq + 1'b1);
                    deliver_seq  = i_pkt_seq;
                    status       = ST_DELIVERED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master       <= 1'b0;
            r_expect_valid <= 1'b0;
            r_expect_seq   <= '0;
            r_gap_end      <= '0;
            r_lost         <= '0;
        end else if (i_accept) begin
            r_master       <= n_master;
            r_expect_valid <= n_expect_valid;
            r_expect_seq   <= n_expect_seq;
            r_gap_end      <= n_gap_end;
            r_lost         <= n_lost;
        end
    end

    assign o_result.status       = status;
    assign o_result.deliver_seq  = deliver_seq;
    assign o_result.event_taken  = taken;
    assign o_result.master_path  = n_master;
    assign o_result.pending_lost = n_lost;

endmodule

FILE: rtl/dual_path_rtp_merge_controller.sv
// Merges two redundant RTP paths. Each input transaction is a time tick or a read call, and
// each yields exactly one result transaction. The block takes one transaction per clock while
// the output is not stalled: path ages, online flags, master selection and gap tracking are
// all updated by a single level of compare and counter logic; the result lands in one output
// register in the cycle after acceptance. A stalled output holds the register and stalls the
// input in turn. The offline threshold register sits at byte address 0 of the APB port.
module dual_path_rtp_merge_controller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_cmd,
    input  logic                        i_src_index,
    input  logic [15:0]                 i_pkt_seq,
    input  logic                        i_secondary_has,
    input  logic                        i_master_read_ok,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_status,
    output logic [15:0]                 o_deliver_seq,
    output logic                        o_event_taken,
    output logic                        o_master_path,
    output logic [16:0]                 o_pending_lost
);
    import dprmc_pkg::*;

    logic [AGE_W-1:0] r_threshold;
    logic             r_out_valid;
    t_result          r_result;
    t_result          result;
    t_path_info       info;
    logic             accept;
    logic             recovering;
    logic             reg_hit;

    assign reg_hit = (paddr[2] == REG_THRESHOLD);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {8'd0, r_threshold} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_threshold <= pwdata[AGE_W-1:0];
        end
    end

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    dprmc_paths u_paths (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cmd        (i_cmd),
        .i_src_index  (i_src_index),
        .i_recovering (recovering),
        .i_threshold  (r_threshold),
        .o_info       (info)
    );

    dprmc_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_cmd            (i_cmd),
        .i_src_index      (i_src_index),
        .i_pkt_seq        (i_pkt_seq),
        .i_secondary_has  (i_secondary_has),
        .i_master_read_ok (i_master_read_ok),
        .i_info           (info),
        .o_recovering     (recovering),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_result.status;
    assign o_deliver_seq  = r_result.deliver_seq;
    assign o_event_taken  = r_result.event_taken;
    assign o_master_path  = r_result.master_path;
    assign o_pending_lost = r_result.pending_lost;

endmodule

FILE: rtl/dprmc_checker.sv
`include "dual_path_rtp_merge_controller_assert.svh"

module dprmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [15:0] o_deliver_seq,
    input logic        o_event_taken,
    input logic [16:0] o_pending_lost
);
    import dprmc_pkg::*;

    `DPRMC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_deliver_seq) && $stable(o_pending_lost))
    `DPRMC_ASSERT_SAME(a_tick_no_event, i_clk, i_rst_n, o_valid && (o_status == ST_TICK), !o_event_taken)
    `DPRMC_ASSERT_SAME(a_loss_count, i_clk, i_rst_n, o_valid && (o_status == ST_LOSS), o_event_taken && (o_pending_lost >= 17'd2))
    `DPRMC_ASSERT_SAME(a_fail_clears, i_clk, i_rst_n, o_valid && (o_status == ST_RECOVERY_FAIL), !o_event_taken && (o_pending_lost == 17'd0))

endmodule

bind dual_path_rtp_merge_controller dprmc_checker u_dprmc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_deliver_seq  (o_deliver_seq),
    .o_event_taken  (o_event_taken),
    .o_pending_lost (o_pending_lost)
);
